// ----- rtl/core/pals_pkg.sv -----
// Package for the polyline arc-length sampler.
// Sizes, request and status codes, controller states and the cell control struct.
// No dependencies.
package pals_pkg;

    localparam int MAX_V = 64;
    localparam int IDX_W = $clog2(MAX_V);
    localparam int CNT_W = $clog2(MAX_V + 1);

    localparam logic [38:0] LEN_MAX = {39{1'b1}};
    localparam logic [16:0] ONE_Q16 = 17'd65536;

    localparam logic [1:0] OP_CLEAR  = 2'd0;
    localparam logic [1:0] OP_APPEND = 2'd1;
    localparam logic [1:0] OP_QUERY  = 2'd2;
    localparam logic [1:0] OP_RSVD   = 2'd3;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE,
        S_APP_SQ,
        S_APP_SQRT,
        S_APP_WR,
        S_Q_MUL,
        S_Q_WALK,
        S_Q_DIV,
        S_Q_LERPX,
        S_Q_LERPY,
        S_FIN
    } t_state;

    typedef struct packed {
        logic shift;
        logic wr;
    } t_ctl;

endpackage

// ----- rtl/core/pals_cell.sv -----
// One vertex cell of the rotating store: x, y and the length of the segment ending here.
// Depends on pals_pkg.
module pals_cell (
    input  logic               i_clk,
    input  pals_pkg::t_ctl     i_ctl,
    input  logic               i_sel,
    input  logic signed [31:0] i_nx,
    input  logic signed [31:0] i_ny,
    input  logic        [32:0] i_nlen,
    input  logic signed [31:0] i_wx,
    input  logic signed [31:0] i_wy,
    input  logic        [32:0] i_wlen,
    output logic signed [31:0] o_x,
    output logic signed [31:0] o_y,
    output logic        [32:0] o_len
);

    logic signed [31:0] r_x;
    logic signed [31:0] r_y;
    logic        [32:0] r_len;

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr && i_sel) begin
            r_x   <= i_wx;
            r_y   <= i_wy;
            r_len <= i_wlen;
        end else if (i_ctl.shift) begin
            r_x   <= i_nx;
            r_y   <= i_ny;
            r_len <= i_nlen;
        end
    end

    assign o_x   = r_x;
    assign o_y   = r_y;
    assign o_len = r_len;

endmodule

// ----- rtl/core/pals_ctrl.sv -----
// Controller: request decode, square root, length walk, divider, interpolation, result register.
// Depends on pals_pkg; drives the cell chain through pals_pkg::t_ctl.
module pals_ctrl (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  logic [1:0]                i_op,
    input  logic signed [31:0]        i_vx,
    input  logic signed [31:0]        i_vy,
    input  logic [16:0]               i_param,
    input  logic signed [31:0]        i_hx,
    input  logic signed [31:0]        i_hy,
    input  logic [32:0]               i_hlen,
    output pals_pkg::t_ctl            o_ctl,
    output logic [pals_pkg::CNT_W-1:0] o_wr_idx,
    output logic signed [31:0]        o_wx,
    output logic signed [31:0]        o_wy,
    output logic [32:0]               o_wlen,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output logic signed [31:0]        o_px,
    output logic signed [31:0]        o_py,
    output logic [38:0]               o_total_len,
    output logic signed [31:0]        o_min_x,
    output logic signed [31:0]        o_max_x,
    output logic signed [31:0]        o_min_y,
    output logic signed [31:0]        o_max_y,
    output logic [6:0]                o_vertex_count,
    output logic [1:0]                o_status
);

    pals_pkg::t_state r_state, n_state;

    logic [pals_pkg::CNT_W-1:0] r_count;
    logic [38:0]        r_sum;
    logic signed [31:0] r_minx, r_maxx, r_miny, r_maxy;
    logic signed [31:0] r_first_x, r_first_y, r_last_x, r_last_y;
    logic signed [31:0] r_vx, r_vy;
    logic [16:0]        r_t;
    logic [65:0]        r_num, r_res, r_bit;
    logic [55:0]        r_target;
    logic [39:0]        r_acc;
    logic [pals_pkg::IDX_W-1:0] r_k;
    logic               r_found;
    logic signed [31:0] r_prev_x, r_prev_y, r_ax, r_ay, r_bx, r_by;
    logic [32:0]        r_s;
    logic [49:0]        r_rem, r_dv;
    logic [16:0]        r_quo;
    logic [4:0]         r_db;
    logic signed [31:0] r_px, r_py;
    logic [1:0]         r_status;
    logic               r_o_valid;
    logic signed [31:0] r_o_px, r_o_py, r_o_minx, r_o_maxx, r_o_miny, r_o_maxy;
    logic [38:0]        r_o_sum;
    logic [6:0]         r_o_cnt;
    logic [1:0]         r_o_status;

    logic               accept;
    logic [16:0]        t_clamp;
    logic signed [32:0] dx, dy;
    logic [31:0]        ax, ay;
    logic [64:0]        sq_sum;
    logic [65:0]        trial;
    logic               sqrt_last;
    logic [39:0]        sum_ext;
    logic [pals_pkg::CNT_W-1:0] kk;
    logic               walk_act, walk_hit, walk_last;
    logic [39:0]        acc_s;
    logic [16:0]        frac;
    logic signed [31:0] la, lb;
    logic signed [32:0] ld;
    logic [32:0]        lmag;
    logic [49:0]        lp;
    logic [50:0]        lq;
    logic signed [31:0] lres;
    logic               out_free;

    assign accept    = i_in_valid && o_in_ready;
    assign t_clamp   = (i_param > pals_pkg::ONE_Q16) ? pals_pkg::ONE_Q16 : i_param;
    assign dx        = 33'(r_vx) - 33'(r_last_x);
    assign dy        = 33'(r_vy) - 33'(r_last_y);
    assign ax        = dx[32] ? 32'(-dx) : dx[31:0];
    assign ay        = dy[32] ? 32'(-dy) : dy[31:0];
    assign sq_sum    = 65'(64'(ax) * 64'(ax)) + 65'(64'(ay) * 64'(ay));
    assign trial     = r_res + r_bit;
    assign sqrt_last = r_bit[0];
    assign sum_ext   = 40'(r_sum) + 40'(r_res[32:0]);
    assign kk        = pals_pkg::CNT_W'(r_k);
    assign walk_act  = (kk != '0) && (kk < r_count) && !r_found;
    assign acc_s     = r_acc + 40'(i_hlen);
    assign walk_hit  = walk_act && ({acc_s, 16'd0} >= r_target);
    assign walk_last = (r_k == pals_pkg::IDX_W'(pals_pkg::MAX_V - 1));
    assign frac      = (r_s == '0) ? 17'd0
                     : ((r_quo > pals_pkg::ONE_Q16) ? pals_pkg::ONE_Q16 : r_quo);
    assign la        = (r_state == pals_pkg::S_Q_LERPX) ? r_ax : r_ay;
    assign lb        = (r_state == pals_pkg::S_Q_LERPX) ? r_bx : r_by;
    assign ld        = 33'(lb) - 33'(la);
    assign lmag      = ld[32] ? 33'(-ld) : 33'(ld);
    assign lp        = 50'(lmag) * 50'(frac);
    assign lq        = ld[32] ? ((51'(lp) + 51'd65535) >> 16) : (51'(lp) >> 16);
    assign lres      = ld[32] ? 32'(la - 32'(lq)) : 32'(la + 32'(lq));
    assign out_free  = !r_o_valid || i_out_ready;

    always_comb begin
        n_state = r_state;
        case (r_state)
            pals_pkg::S_IDLE: begin
                if (accept) begin
                    case (i_op)
                        pals_pkg::OP_APPEND: begin
                            if (r_count >= pals_pkg::CNT_W'(pals_pkg::MAX_V))
                                n_state = pals_pkg::S_FIN;
                            else if (r_count == '0)
                                n_state = pals_pkg::S_APP_WR;
                            else
                                n_state = pals_pkg::S_APP_SQ;
                        end
                        pals_pkg::OP_QUERY: begin
                            if (r_count < pals_pkg::CNT_W'(2) || t_clamp == '0
                                || t_clamp == pals_pkg::ONE_Q16)
                                n_state = pals_pkg::S_FIN;
                            else
                                n_state = pals_pkg::S_Q_MUL;
                        end
                        default: n_state = pals_pkg::S_FIN;
                    endcase
                end
            end
            pals_pkg::S_APP_SQ:   n_state = pals_pkg::S_APP_SQRT;
            pals_pkg::S_APP_SQRT: if (sqrt_last) n_state = pals_pkg::S_APP_WR;
            pals_pkg::S_APP_WR:   n_state = pals_pkg::S_FIN;
            pals_pkg::S_Q_MUL:    n_state = pals_pkg::S_Q_WALK;
            pals_pkg::S_Q_WALK: begin
                if (walk_last)
                    n_state = (r_found || walk_hit) ? pals_pkg::S_Q_DIV : pals_pkg::S_FIN;
            end
            pals_pkg::S_Q_DIV:    if (r_db == '0) n_state = pals_pkg::S_Q_LERPX;
            pals_pkg::S_Q_LERPX:  n_state = pals_pkg::S_Q_LERPY;
            pals_pkg::S_Q_LERPY:  n_state = pals_pkg::S_FIN;
            pals_pkg::S_FIN:      if (out_free) n_state = pals_pkg::S_IDLE;
            default:              n_state = pals_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_ctl      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            pals_pkg::S_IDLE:   o_in_ready = 1'b1;
            pals_pkg::S_APP_WR: o_ctl.wr = 1'b1;
            pals_pkg::S_Q_WALK: o_ctl.shift = 1'b1;
            default:            o_ctl = '0;
        endcase
    end

    assign o_wr_idx = r_count;
    assign o_wx     = r_vx;
    assign o_wy     = r_vy;
    assign o_wlen   = r_res[32:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= pals_pkg::S_IDLE;
            r_count   <= '0;
            r_sum     <= '0;
            r_minx    <= '0;
            r_maxx    <= '0;
            r_miny    <= '0;
            r_maxy    <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == pals_pkg::S_FIN && out_free)
                r_o_valid <= 1'b1;
            else if (i_out_ready)
                r_o_valid <= 1'b0;
            case (r_state)
                pals_pkg::S_IDLE: begin
                    if (accept) begin
                        r_vx     <= i_vx;
                        r_vy     <= i_vy;
                        r_t      <= t_clamp;
                        case (i_op)
                            pals_pkg::OP_CLEAR: begin
                                r_count  <= '0;
                                r_sum    <= '0;
                                r_minx   <= '0;
                                r_maxx   <= '0;
                                r_miny   <= '0;
                                r_maxy   <= '0;
                                r_px     <= '0;
                                r_py     <= '0;
                                r_status <= pals_pkg::ST_OK;
                            end
                            pals_pkg::OP_APPEND: begin
                                r_px     <= '0;
                                r_py     <= '0;
                                r_status <= (r_count >= pals_pkg::CNT_W'(pals_pkg::MAX_V))
                                          ? pals_pkg::ST_FULL : pals_pkg::ST_OK;
                            end
                            pals_pkg::OP_QUERY: begin
                                if (r_count == '0) begin
                                    r_px     <= '0;
                                    r_py     <= '0;
                                    r_status <= pals_pkg::ST_EMPTY;
                                end else if (r_count == pals_pkg::CNT_W'(1) || t_clamp == '0) begin
                                    r_px     <= r_first_x;
                                    r_py     <= r_first_y;
                                    r_status <= pals_pkg::ST_OK;
                                end else if (t_clamp == pals_pkg::ONE_Q16) begin
                                    r_px     <= r_last_x;
                                    r_py     <= r_last_y;
                                    r_status <= pals_pkg::ST_OK;
                                end else begin
                                    r_px     <= '0;
                                    r_py     <= '0;
                                    r_status <= pals_pkg::ST_OK;
                                end
                            end
                            default: begin
                                r_px     <= '0;
                                r_py     <= '0;
                                r_status <= pals_pkg::ST_OK;
                            end
                        endcase
                    end
                end
                pals_pkg::S_APP_SQ: begin
                    r_num <= 66'(sq_sum);
                    r_res <= '0;
                    r_bit <= 66'(1) << 64;
                end
                pals_pkg::S_APP_SQRT: begin
                    if (r_num >= trial) begin
                        r_num <= r_num - trial;
                        r_res <= (r_res >> 1) + r_bit;
                    end else begin
                        r_res <= r_res >> 1;
                    end
                    r_bit <= r_bit >> 2;
                end
                pals_pkg::S_APP_WR: begin
                    if (r_count == '0) begin
                        r_minx    <= r_vx;
                        r_maxx    <= r_vx;
                        r_miny    <= r_vy;
                        r_maxy    <= r_vy;
                        r_first_x <= r_vx;
                        r_first_y <= r_vy;
                    end else begin
                        r_sum <= (sum_ext > 40'(pals_pkg::LEN_MAX)) ? pals_pkg::LEN_MAX
                                                                    : sum_ext[38:0];
                        if (r_vx < r_minx) r_minx <= r_vx;
                        if (r_vx > r_maxx) r_maxx <= r_vx;
                        if (r_vy < r_miny) r_miny <= r_vy;
                        if (r_vy > r_maxy) r_maxy <= r_vy;
                    end
                    r_last_x <= r_vx;
                    r_last_y <= r_vy;
                    r_count  <= r_count + pals_pkg::CNT_W'(1);
                end
                pals_pkg::S_Q_MUL: begin
                    r_target <= 56'(r_t) * 56'(r_sum);
                    r_acc    <= '0;
                    r_k      <= '0;
                    r_found  <= 1'b0;
                end
                pals_pkg::S_Q_WALK: begin
                    if (walk_act)
                        r_acc <= acc_s;
                    if (walk_hit) begin
                        r_found <= 1'b1;
                        r_rem   <= 50'(r_target - {r_acc, 16'd0});
                        r_s     <= i_hlen;
                        r_dv    <= {1'b0, i_hlen, 16'd0};
                        r_ax    <= r_prev_x;
                        r_ay    <= r_prev_y;
                        r_bx    <= i_hx;
                        r_by    <= i_hy;
                    end
                    r_prev_x <= i_hx;
                    r_prev_y <= i_hy;
                    r_k      <= r_k + pals_pkg::IDX_W'(1);
                    r_db     <= 5'd16;
                    r_quo    <= '0;
                    if (walk_last && !(r_found || walk_hit)) begin
                        r_px <= r_last_x;
                        r_py <= r_last_y;
                    end
                end
                pals_pkg::S_Q_DIV: begin
                    if (r_rem >= r_dv) begin
                        r_rem <= r_rem - r_dv;
                        r_quo <= {r_quo[15:0], 1'b1};
                    end else begin
                        r_quo <= {r_quo[15:0], 1'b0};
                    end
                    r_dv <= r_dv >> 1;
                    r_db <= r_db - 5'd1;
                end
                pals_pkg::S_Q_LERPX: r_px <= lres;
                pals_pkg::S_Q_LERPY: r_py <= lres;
                pals_pkg::S_FIN: begin
                    if (out_free) begin
                        r_o_px     <= r_px;
                        r_o_py     <= r_py;
                        r_o_sum    <= r_sum;
                        r_o_minx   <= r_minx;
                        r_o_maxx   <= r_maxx;
                        r_o_miny   <= r_miny;
                        r_o_maxy   <= r_maxy;
                        r_o_cnt    <= 7'(r_count);
                        r_o_status <= r_status;
                    end
                end
                default: ;
            endcase
        end
    end

    assign o_out_valid    = r_o_valid;
    assign o_px           = r_o_px;
    assign o_py           = r_o_py;
    assign o_total_len    = r_o_sum;
    assign o_min_x        = r_o_minx;
    assign o_max_x        = r_o_maxx;
    assign o_min_y        = r_o_miny;
    assign o_max_y        = r_o_maxy;
    assign o_vertex_count = r_o_cnt;
    assign o_status       = r_o_status;

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= pals_pkg::CNT_W'(pals_pkg::MAX_V))
        else $error("vertex count above capacity");

    a_walk_needs_two: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == pals_pkg::S_Q_WALK) |-> (r_count >= pals_pkg::CNT_W'(2)))
        else $error("walk started with fewer than two vertices");

    a_fin_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == pals_pkg::S_FIN && out_free) |=> r_o_valid)
        else $error("finished request did not reach the output register");

    a_no_write_in_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_ctl.wr && o_ctl.shift))
        else $error("cell write during rotation");

endmodule

// ----- rtl/core/polyline_arc_length_sampler_top.sv -----
// Polyline arc-length sampler: vertices are held in a ring of MAX_V cells that
// rotates once per walking query so the controller sees every segment at the head cell.
// An append to a non-empty store computes two squares, then a 33-step square root;
// the first append after a clear writes its cell directly. A query that walks makes
// one full ring rotation, then runs a 17-step divider and two interpolation steps,
// or finishes after the rotation when the walk finds no segment; clear, empty,
// single-vertex, t = 0 and t = 1.0 queries, unused op codes and dropped appends
// go straight to the finish state. One request is in work at a time; the result register
// lets the next request be taken while a result waits, and a request that
// finishes while that result still waits stalls until it is taken.
// Depends on pals_pkg, pals_cell and pals_ctrl.
module polyline_arc_length_sampler_top (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [1:0]         i_op,
    input  logic signed [31:0] i_vx,
    input  logic signed [31:0] i_vy,
    input  logic [16:0]        i_param,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic signed [31:0] o_px,
    output logic signed [31:0] o_py,
    output logic [38:0]        o_total_len,
    output logic signed [31:0] o_min_x,
    output logic signed [31:0] o_max_x,
    output logic signed [31:0] o_min_y,
    output logic signed [31:0] o_max_y,
    output logic [6:0]         o_vertex_count,
    output logic [1:0]         o_status
);

    pals_pkg::t_ctl             ctl;
    logic [pals_pkg::CNT_W-1:0] wr_idx;
    logic signed [31:0]         wx, wy;
    logic [32:0]                wlen;
    logic signed [31:0]         cx   [pals_pkg::MAX_V];
    logic signed [31:0]         cy   [pals_pkg::MAX_V];
    logic [32:0]                clen [pals_pkg::MAX_V];

    for (genvar j = 0; j < pals_pkg::MAX_V; j++) begin : g_cell
        localparam int NB = (j + 1) % pals_pkg::MAX_V;
        pals_cell u_cell (
            .i_clk  (i_clk),
            .i_ctl  (ctl),
            .i_sel  (wr_idx == pals_pkg::CNT_W'(j)),
            .i_nx   (cx[NB]),
            .i_ny   (cy[NB]),
            .i_nlen (clen[NB]),
            .i_wx   (wx),
            .i_wy   (wy),
            .i_wlen (wlen),
            .o_x    (cx[j]),
            .o_y    (cy[j]),
            .o_len  (clen[j])
        );
    end

    pals_ctrl u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_op           (i_op),
        .i_vx           (i_vx),
        .i_vy           (i_vy),
        .i_param        (i_param),
        .i_hx           (cx[0]),
        .i_hy           (cy[0]),
        .i_hlen         (clen[0]),
        .o_ctl          (ctl),
        .o_wr_idx       (wr_idx),
        .o_wx           (wx),
        .o_wy           (wy),
        .o_wlen         (wlen),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_px           (o_px),
        .o_py           (o_py),
        .o_total_len    (o_total_len),
        .o_min_x        (o_min_x),
        .o_max_x        (o_max_x),
        .o_min_y        (o_min_y),
        .o_max_y        (o_max_y),
        .o_vertex_count (o_vertex_count),
        .o_status       (o_status)
    );

endmodule
